### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define RTP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define RTP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rtp_pkg.sv
`default_nettype none
package rtp_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  tone;
		logic        sharp;
		logic [3:0]  octave;
		logic [5:0]  length;
		logic        dotted;
		logic [15:0] tempo;
		logic [7:0]  note_count;
		logic        ok;
		logic        final_res;
	} out_item_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NOTES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OCTAVE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TEMPO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_FLOOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_CEILING = 3'd5;

	localparam logic [7:0]  RST_MAX_NOTES      = 8'd255;
	localparam logic [5:0]  RST_START_LENGTH   = 6'd4;
	localparam logic [3:0]  RST_START_OCTAVE   = 4'd4;
	localparam logic [15:0] RST_START_TEMPO    = 16'd63;
	localparam logic [3:0]  RST_OCTAVE_FLOOR   = 4'd4;
	localparam logic [3:0]  RST_OCTAVE_CEILING = 4'd7;

	localparam logic [1:0] SEC_NAME = 2'd0;
	localparam logic [1:0] SEC_DEF  = 2'd1;
	localparam logic [1:0] SEC_BODY = 2'd2;

	localparam logic [2:0] D_KEY      = 3'd0;
	localparam logic [2:0] D_AFTERKEY = 3'd1;
	localparam logic [2:0] D_SKIP     = 3'd2;
	localparam logic [2:0] D_AFTEREQ  = 3'd3;
	localparam logic [2:0] D_NUM      = 3'd4;
	localparam logic [2:0] D_AFTERVAL = 3'd5;

	localparam logic [2:0] N_START   = 3'd0;
	localparam logic [2:0] N_DUR     = 3'd1;
	localparam logic [2:0] N_PRETONE = 3'd2;
	localparam logic [2:0] N_SHARP   = 3'd3;
	localparam logic [2:0] N_MODS    = 3'd4;
	localparam logic [2:0] N_OCT     = 3'd5;
	localparam logic [2:0] N_DONE    = 3'd6;
	localparam logic [2:0] N_BAD     = 3'd7;

	localparam logic [2:0] TONE_PAUSE = 3'd7;
	localparam logic [5:0] LEN_FALLBACK = 6'd4;
	localparam logic [15:0] LEN_MAX_DUR = 16'd32;
	localparam logic [15:0] LEN_MAX_SET = 16'd64;
	localparam logic [15:0] NUM_SAT = 16'hFFFF;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LG    = 8'h67;
	localparam logic [7:0] CH_LO    = 8'h6F;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CASE_OFS = 8'h20;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) ? c + CASE_OFS : c;
	endfunction

	// bit 3 set: not a tone letter
	function automatic logic [3:0] tone_code(input logic [7:0] c);
		logic [7:0] l;
		logic [7:0] d;
		l = to_lower(c);
		d = l - CH_LA;
		if ((l >= CH_LA) && (l <= CH_LG)) return {1'b0, d[2:0]};
		if (l == CH_LP) return {1'b0, TONE_PAUSE};
		return 4'b1000;
	endfunction

	function automatic logic [5:0] norm_len(input logic [15:0] v);
		case (v)
			16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32: return v[5:0];
			default: return LEN_FALLBACK;
		endcase
	endfunction

	function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
		return (v > {4'b0, NUM_SAT}) ? NUM_SAT : v[15:0];
	endfunction

	function automatic logic [3:0] clamp_oct(input logic [15:0] v, input logic [3:0] lo,
			input logic [3:0] hi);
		if (v < {12'b0, lo}) return lo;
		if (v > {12'b0, hi}) return hi;
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ringtone_text_parser_core.sv
// Latency: a byte's results enter the output queue at its accept edge and, if
// the queue was empty, show on out_data from the next cycle. Throughput: one
// byte per cycle; a byte that closes a note and the string puts two beats into
// the 4-entry output queue, and in_ready drops while under two slots are free.
// Reset: arst_n clears the parser and queue at once and loads config defaults.
`default_nettype none
module ringtone_text_parser_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire rtp_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output rtp_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rtp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtp_pkg::*;

	logic [7:0]  max_notes_q;
	logic [5:0]  start_length_q;
	logic [3:0]  start_octave_q;
	logic [15:0] start_tempo_q;
	logic [3:0]  oct_floor_q;
	logic [3:0]  oct_ceil_q;

	logic [1:0]  sec_q, sec_d;
	logic [2:0]  sub_q, sub_d;
	logic [7:0]  key_q, key_d;
	logic [15:0] acc_q, acc_d;
	logic [5:0]  dlen_q, dlen_d;
	logic [3:0]  doct_q, doct_d;
	logic [15:0] tempo_q, tempo_d;
	logic [2:0]  tone_q, tone_d;
	logic        sharp_q, sharp_d;
	logic [3:0]  noct_q, noct_d;
	logic [5:0]  nlen_q, nlen_d;
	logic        dot_q, dot_d;
	logic [7:0]  prod_q, prod_d;
	logic        ended_q, ended_d;

	out_item_t   fifo_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;

	logic        in_fire, pop;
	logic [1:0]  n_res;
	out_item_t   res0, res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_notes_q    <= RST_MAX_NOTES;
			start_length_q <= RST_START_LENGTH;
			start_octave_q <= RST_START_OCTAVE;
			start_tempo_q  <= RST_START_TEMPO;
			oct_floor_q    <= RST_OCTAVE_FLOOR;
			oct_ceil_q     <= RST_OCTAVE_CEILING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_NOTES:      max_notes_q    <= cfg_data[7:0];
				CFG_START_LENGTH:   start_length_q <= cfg_data[5:0];
				CFG_START_OCTAVE:   start_octave_q <= cfg_data[3:0];
				CFG_START_TEMPO:    start_tempo_q  <= cfg_data;
				CFG_OCTAVE_FLOOR:   oct_floor_q    <= cfg_data[3:0];
				CFG_OCTAVE_CEILING: oct_ceil_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	function automatic out_item_t make_note(input logic [2:0] sub, input logic [2:0] tone,
			input logic sharp, input logic [3:0] noct, input logic [5:0] nlen,
			input logic dot, input logic [15:0] acc, input logic [3:0] doct,
			input logic [3:0] lo, input logic [3:0] hi);
		out_item_t r;
		logic [3:0] o;
		r = '0;
		o = (sub == N_OCT) ? clamp_oct(acc, lo, hi) : noct;
		r.tone   = tone;
		r.sharp  = (tone == TONE_PAUSE) ? 1'b0 : sharp;
		r.octave = (tone == TONE_PAUSE) ? doct : o;
		r.length = nlen;
		r.dotted = dot;
		return r;
	endfunction

	function automatic logic tok_live(input logic [2:0] sub);
		return (sub >= N_SHARP) && (sub <= N_DONE);
	endfunction

	assign in_ready = (cnt_q <= 3'd2);
	assign in_fire  = in_valid && in_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = fifo_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_comb begin
		logic [7:0]  c;
		logic        lst;
		logic [3:0]  tc;
		logic        ws, dig;
		logic [15:0] acc_mac, acc_new;
		logic [2:0]  av_sub;
		logic [7:0]  av_key;
		logic        do_apply, do_mods, begin_tok;
		logic        note_emit, summ, ok;
		out_item_t   note_res, summ_res;

		c   = in_data.ch;
		lst = in_data.last;
		tc  = tone_code(c);
		ws  = is_ws(c);
		dig = is_digit(c);
		acc_mac = acc_digit(acc_q, c);
		acc_new = {12'b0, c[3:0]};
		av_sub  = ws ? D_AFTERVAL : ((c == CH_COMMA) ? D_KEY : D_AFTERKEY);
		av_key  = (ws || (c == CH_COMMA)) ? key_q : to_lower(c);

		sec_d = sec_q; sub_d = sub_q; key_d = key_q; acc_d = acc_q;
		dlen_d = dlen_q; doct_d = doct_q; tempo_d = tempo_q;
		tone_d = tone_q; sharp_d = sharp_q; noct_d = noct_q; nlen_d = nlen_q; dot_d = dot_q;
		prod_d = prod_q; ended_d = ended_q;
		do_apply = 1'b0; do_mods = 1'b0; begin_tok = 1'b0;
		note_emit = 1'b0; summ = 1'b0; ok = 1'b0;
		note_res = '0; summ_res = '0;

		if (in_fire && !ended_q) begin
			if (c != CH_NUL) begin
				unique case (sec_q)
					SEC_NAME: begin
						if (c == CH_COLON) begin
							sec_d   = SEC_DEF;
							sub_d   = D_KEY;
							dlen_d  = norm_len({10'b0, start_length_q});
							doct_d  = start_octave_q;
							tempo_d = start_tempo_q;
						end
					end
					SEC_DEF: begin
						if (c == CH_COLON) begin
							do_apply  = (sub_q == D_NUM);
							sec_d     = SEC_BODY;
							begin_tok = 1'b1;
						end else begin
							case (sub_q)
								D_KEY: begin
									if (!ws) begin
										key_d = to_lower(c);
										sub_d = D_AFTERKEY;
									end
								end
								D_AFTERKEY: begin
									if (!ws) begin
										if (c == CH_EQ) sub_d = D_AFTEREQ;
										else if (c == CH_COMMA) sub_d = D_KEY;
										else sub_d = D_SKIP;
									end
								end
								D_SKIP: begin
									if (c == CH_COMMA) sub_d = D_KEY;
								end
								D_AFTEREQ: begin
									if (dig) begin
										acc_d = acc_new;
										sub_d = D_NUM;
									end else if (!ws) begin
										sub_d = av_sub;
										key_d = av_key;
									end
								end
								D_NUM: begin
									if (dig) begin
										acc_d = acc_mac;
									end else begin
										do_apply = 1'b1;
										sub_d    = av_sub;
										key_d    = av_key;
									end
								end
								default: begin
									if (!ws) begin
										sub_d = av_sub;
										key_d = av_key;
									end
								end
							endcase
						end
					end
					default: begin
						if (c == CH_COMMA) begin
							if (tok_live(sub_q) && (prod_q < max_notes_q)) begin
								note_emit = 1'b1;
								note_res  = make_note(sub_q, tone_q, sharp_q, noct_q, nlen_q,
									dot_q, acc_q, doct_q, oct_floor_q, oct_ceil_q);
								prod_d    = prod_q + 8'd1;
							end
							begin_tok = 1'b1;
						end else begin
							case (sub_q)
								N_START: begin
									if (dig) begin
										acc_d = acc_new;
										sub_d = N_DUR;
									end else if (!ws) begin
										if (!tc[3]) begin
											tone_d = tc[2:0];
											sub_d  = N_SHARP;
										end else begin
											sub_d = N_BAD;
										end
									end
								end
								N_DUR: begin
									if (dig) begin
										acc_d = acc_mac;
									end else begin
										nlen_d = norm_len((acc_q > LEN_MAX_DUR) ? LEN_MAX_DUR : acc_q);
										if (ws) begin
											sub_d = N_PRETONE;
										end else if (!tc[3]) begin
											tone_d = tc[2:0];
											sub_d  = N_SHARP;
										end else begin
											sub_d = N_BAD;
										end
									end
								end
								N_PRETONE: begin
									if (!ws) begin
										if (!tc[3]) begin
											tone_d = tc[2:0];
											sub_d  = N_SHARP;
										end else begin
											sub_d = N_BAD;
										end
									end
								end
								N_SHARP: begin
									if (c == CH_HASH) begin
										sharp_d = 1'b1;
										sub_d   = N_MODS;
									end else begin
										do_mods = 1'b1;
									end
								end
								N_MODS: do_mods = 1'b1;
								N_OCT: begin
									if (dig) begin
										acc_d = acc_mac;
									end else begin
										noct_d  = clamp_oct(acc_q, oct_floor_q, oct_ceil_q);
										do_mods = 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
				endcase
			end

			if (do_apply) begin
				if ((key_q == CH_LD) && (acc_q >= 16'd1) && (acc_q <= LEN_MAX_SET))
					dlen_d = norm_len(acc_q);
				else if ((key_q == CH_LO) && (acc_q >= {12'b0, oct_floor_q})
						&& (acc_q <= {12'b0, oct_ceil_q}))
					doct_d = acc_q[3:0];
				else if ((key_q == CH_LB) && (acc_q != 16'd0))
					tempo_d = acc_q;
			end

			if (do_mods) begin
				if (ws) begin
					sub_d = N_MODS;
				end else if (c == CH_DOT) begin
					dot_d = 1'b1;
					sub_d = N_MODS;
				end else if (dig) begin
					acc_d = acc_new;
					sub_d = N_OCT;
				end else begin
					sub_d = N_DONE;
				end
			end

			if (begin_tok) begin
				sub_d   = N_START;
				tone_d  = 3'd0;
				sharp_d = 1'b0;
				dot_d   = 1'b0;
				noct_d  = doct_d;
				nlen_d  = dlen_d;
			end

			if ((c == CH_NUL) || lst) begin
				if ((sec_d == SEC_BODY) && tok_live(sub_d) && (prod_d < max_notes_q)) begin
					note_emit = 1'b1;
					note_res  = make_note(sub_d, tone_d, sharp_d, noct_d, nlen_d, dot_d,
						acc_d, doct_d, oct_floor_q, oct_ceil_q);
					prod_d    = prod_d + 8'd1;
				end
				ok   = (sec_d == SEC_BODY);
				summ = 1'b1;
				summ_res.kind       = 1'b1;
				summ_res.tempo      = ok ? tempo_d : start_tempo_q;
				summ_res.note_count = prod_d;
				summ_res.ok         = ok;
				summ_res.final_res  = 1'b1;
				ended_d = 1'b1;
			end
		end

		if (in_fire && lst) begin
			sec_d   = SEC_NAME;
			sub_d   = N_START;
			key_d   = 8'd0;
			acc_d   = 16'd0;
			tone_d  = 3'd0;
			sharp_d = 1'b0;
			noct_d  = 4'd0;
			nlen_d  = 6'd0;
			dot_d   = 1'b0;
			prod_d  = 8'd0;
			ended_d = 1'b0;
		end

		n_res = {1'b0, note_emit} + {1'b0, summ};
		res0  = note_emit ? note_res : summ_res;
		res1  = summ_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= SEC_NAME;
			sub_q   <= N_START;
			key_q   <= 8'd0;
			acc_q   <= 16'd0;
			dlen_q  <= RST_START_LENGTH;
			doct_q  <= RST_START_OCTAVE;
			tempo_q <= RST_START_TEMPO;
			tone_q  <= 3'd0;
			sharp_q <= 1'b0;
			noct_q  <= 4'd0;
			nlen_q  <= 6'd0;
			dot_q   <= 1'b0;
			prod_q  <= 8'd0;
			ended_q <= 1'b0;
		end else begin
			sec_q   <= sec_d;
			sub_q   <= sub_d;
			key_q   <= key_d;
			acc_q   <= acc_d;
			dlen_q  <= dlen_d;
			doct_q  <= doct_d;
			tempo_q <= tempo_d;
			tone_q  <= tone_d;
			sharp_q <= sharp_d;
			noct_q  <= noct_d;
			nlen_q  <= nlen_d;
			dot_q   <= dot_d;
			prod_q  <= prod_d;
			ended_q <= ended_d;
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) fifo_q[wr_q] <= res0;
		if (n_res == 2'd2) fifo_q[wr_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + n_res;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_res} - {2'b0, pop};
		end
	end

endmodule
`default_nettype wire

### hw/rtl/rtp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rtp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire rtp_pkg::out_item_t out_data
);
	import rtp_pkg::*;

	`RTP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled beat changed")
	`RTP_ASSERT(a_summary_shape, out_valid && out_data.kind |-> out_data.final_res && out_data.tone == 3'd0 && out_data.sharp == 1'b0 && out_data.octave == 4'd0 && out_data.length == 6'd0 && out_data.dotted == 1'b0, "malformed summary beat")
	`RTP_ASSERT(a_note_shape, out_valid && !out_data.kind |-> (out_data.length == 6'd1 || out_data.length == 6'd2 || out_data.length == 6'd4 || out_data.length == 6'd8 || out_data.length == 6'd16 || out_data.length == 6'd32) && out_data.tempo == 16'd0 && out_data.note_count == 8'd0 && !out_data.ok && !out_data.final_res, "malformed note beat")
	`RTP_ASSERT(a_stall_backlog, !in_ready |-> out_valid, "input stalled with empty output")
	`RTP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "output valid in reset")

endmodule

bind ringtone_text_parser_core rtp_checker u_rtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

### bench/ringtone_text_parser_core_test.sv
`timescale 1ns / 1ps
module ringtone_text_parser_core_test;
	import rtp_pkg::*;

	typedef struct packed {
		logic [2:0] tone;
		logic       sharp;
		logic [3:0] oct;
		logic [5:0] len;
		logic       dot;
	} note_draft_t;

	const int send_idle_by_phase[4] = '{0, 77, 0, 38};
	const int recv_stall_by_phase[4] = '{0, 0, 77, 38};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int faults = 0;
	int sent = 0;

	out_item_t  expected_beats[$];
	logic [7:0] text[$];

	logic [7:0]  cap_notes;
	logic [5:0]  boot_len;
	logic [3:0]  boot_oct;
	logic [15:0] boot_bpm;
	logic [3:0]  oct_lo;
	logic [3:0]  oct_hi;

	logic [1:0]  sec;
	logic [2:0]  step_st;
	logic [7:0]  key_ch;
	logic [15:0] num;
	logic [5:0]  dflt_len;
	logic [3:0]  dflt_oct;
	logic [15:0] bpm;
	note_draft_t cur;
	logic [7:0]  emitted;
	logic        muted;

	ringtone_text_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic numeral(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		if ((c >= CH_UA) && (c <= CH_UZ)) return c + CASE_OFS;
		return c;
	endfunction

	function automatic logic [3:0] pitch(input logic [7:0] c);
		logic [7:0] l;
		logic [7:0] d;
		l = lower(c);
		d = l - CH_LA;
		if ((l >= CH_LA) && (l <= CH_LG)) return {1'b0, d[2:0]};
		if (l == CH_LP) return {1'b0, TONE_PAUSE};
		return 4'b1000;
	endfunction

	function automatic logic [5:0] fit_len(input logic [15:0] v);
		case (v)
			16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32: return v[5:0];
			default: return LEN_FALLBACK;
		endcase
	endfunction

	function automatic logic [15:0] shift_in(input logic [15:0] a, input logic [7:0] c);
		logic [31:0] v;
		v = {16'd0, a} * 32'd10 + {24'd0, c} - {24'd0, CH_0};
		return (v > {16'd0, NUM_SAT}) ? NUM_SAT : v[15:0];
	endfunction

	task automatic restart();
		sec = SEC_NAME;
		step_st = N_START;
		key_ch = '0;
		num = '0;
		cur = '0;
		emitted = '0;
		muted = 1'b0;
	endtask

	task automatic reset_model();
		cap_notes = RST_MAX_NOTES;
		boot_len = RST_START_LENGTH;
		boot_oct = RST_START_OCTAVE;
		boot_bpm = RST_START_TEMPO;
		oct_lo = RST_OCTAVE_FLOOR;
		oct_hi = RST_OCTAVE_CEILING;
		dflt_len = LEN_FALLBACK;
		dflt_oct = RST_START_OCTAVE;
		bpm = RST_START_TEMPO;
		restart();
	endtask

	task automatic open_token();
		step_st = N_START;
		cur = '0;
		cur.oct = dflt_oct;
		cur.len = dflt_len;
	endtask

	task automatic apply_key();
		if (key_ch == CH_LD && num >= 16'd1 && num <= LEN_MAX_SET)
			dflt_len = fit_len(num);
		else if (key_ch == CH_LO && num >= {12'd0, oct_lo} && num <= {12'd0, oct_hi})
			dflt_oct = num[3:0];
		else if (key_ch == CH_LB && num != 16'd0)
			bpm = num;
	endtask

	task automatic after_value(input logic [7:0] c);
		if (blank(c)) begin
			step_st = D_AFTERVAL;
		end else if (c == CH_COMMA) begin
			step_st = D_KEY;
		end else begin
			key_ch = lower(c);
			step_st = D_AFTERKEY;
		end
	endtask

	task automatic defaults_byte(input logic [7:0] c);
		case (step_st)
			D_KEY: begin
				if (!blank(c)) begin
					key_ch = lower(c);
					step_st = D_AFTERKEY;
				end
			end
			D_AFTERKEY: begin
				if (!blank(c)) begin
					if (c == CH_EQ) step_st = D_AFTEREQ;
					else if (c == CH_COMMA) step_st = D_KEY;
					else step_st = D_SKIP;
				end
			end
			D_SKIP: begin
				if (c == CH_COMMA) step_st = D_KEY;
			end
			D_AFTEREQ: begin
				if (!blank(c)) begin
					if (numeral(c)) begin
						num = shift_in(16'd0, c);
						step_st = D_NUM;
					end else begin
						after_value(c);
					end
				end
			end
			D_NUM: begin
				if (numeral(c)) begin
					num = shift_in(num, c);
				end else begin
					apply_key();
					after_value(c);
				end
			end
			default: begin
				if (!blank(c)) after_value(c);
			end
		endcase
	endtask

	task automatic set_octave();
		if (num < {12'd0, oct_lo}) cur.oct = oct_lo;
		else if (num > {12'd0, oct_hi}) cur.oct = oct_hi;
		else cur.oct = num[3:0];
	endtask

	task automatic modifiers(input logic [7:0] c);
		if (blank(c)) begin
			step_st = N_MODS;
		end else if (c == CH_DOT) begin
			cur.dot = 1'b1;
			step_st = N_MODS;
		end else if (numeral(c)) begin
			num = shift_in(16'd0, c);
			step_st = N_OCT;
		end else begin
			step_st = N_DONE;
		end
	endtask

	task automatic take_pitch(input logic [3:0] t);
		if (t[3]) begin
			step_st = N_BAD;
		end else begin
			cur.tone = t[2:0];
			step_st = N_SHARP;
		end
	endtask

	task automatic body_byte(input logic [7:0] c);
		logic [3:0] t;
		t = pitch(c);
		case (step_st)
			N_START: begin
				if (!blank(c)) begin
					if (numeral(c)) begin
						num = shift_in(16'd0, c);
						step_st = N_DUR;
					end else begin
						take_pitch(t);
					end
				end
			end
			N_DUR: begin
				if (numeral(c)) begin
					num = shift_in(num, c);
				end else begin
					cur.len = fit_len((num > LEN_MAX_DUR) ? LEN_MAX_DUR : num);
					if (blank(c)) step_st = N_PRETONE;
					else take_pitch(t);
				end
			end
			N_PRETONE: begin
				if (!blank(c)) take_pitch(t);
			end
			N_SHARP: begin
				if (c == CH_HASH) begin
					cur.sharp = 1'b1;
					step_st = N_MODS;
				end else begin
					modifiers(c);
				end
			end
			N_MODS: modifiers(c);
			N_OCT: begin
				if (numeral(c)) begin
					num = shift_in(num, c);
				end else begin
					set_octave();
					modifiers(c);
				end
			end
			default: ;
		endcase
	endtask

	task automatic close_token();
		out_item_t r;
		if (step_st == N_OCT) set_octave();
		if (step_st >= N_SHARP && step_st <= N_DONE && emitted < cap_notes) begin
			r = '0;
			r.tone = cur.tone;
			r.sharp = (cur.tone == TONE_PAUSE) ? 1'b0 : cur.sharp;
			r.octave = (cur.tone == TONE_PAUSE) ? dflt_oct : cur.oct;
			r.length = cur.len;
			r.dotted = cur.dot;
			expected_beats.push_back(r);
			emitted++;
		end
	endtask

	task automatic parse_byte(input in_item_t b);
		out_item_t r;
		logic [7:0] c;
		c = b.ch;
		if (muted) begin
			if (b.last) restart();
			return;
		end
		if (c != CH_NUL) begin
			if (sec == SEC_NAME) begin
				if (c == CH_COLON) begin
					sec = SEC_DEF;
					step_st = D_KEY;
					dflt_len = fit_len({10'd0, boot_len});
					dflt_oct = boot_oct;
					bpm = boot_bpm;
				end
			end else if (sec == SEC_DEF) begin
				if (c == CH_COLON) begin
					if (step_st == D_NUM) apply_key();
					sec = SEC_BODY;
					open_token();
				end else begin
					defaults_byte(c);
				end
			end else if (c == CH_COMMA) begin
				close_token();
				open_token();
			end else begin
				body_byte(c);
			end
			if (!b.last) return;
		end
		if (sec == SEC_BODY) close_token();
		r = '0;
		r.kind = 1'b1;
		r.tempo = (sec == SEC_BODY) ? bpm : boot_bpm;
		r.note_count = emitted;
		r.ok = (sec == SEC_BODY);
		r.final_res = 1'b1;
		expected_beats.push_back(r);
		if (b.last) restart();
		else muted = 1'b1;
	endtask

	task automatic compare(input string field, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, act_v);
			faults++;
		end
	endtask

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$error("beat with nothing expected: %h", out_data);
					faults++;
				end else begin
					want = expected_beats.pop_front();
					compare("kind", 16'(want.kind), 16'(out_data.kind));
					compare("tone", 16'(want.tone), 16'(out_data.tone));
					compare("sharp", 16'(want.sharp), 16'(out_data.sharp));
					compare("octave", 16'(want.octave), 16'(out_data.octave));
					compare("length", 16'(want.length), 16'(out_data.length));
					compare("dotted", 16'(want.dotted), 16'(out_data.dotted));
					compare("tempo", want.tempo, out_data.tempo);
					compare("note_count", 16'(want.note_count), 16'(out_data.note_count));
					compare("ok", 16'(want.ok), 16'(out_data.ok));
					compare("final_res", 16'(want.final_res), 16'(out_data.final_res));
				end
			end
			if (in_valid && in_ready) parse_byte(in_data);
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {c, fin};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// hold input low until every expected beat is out, then settle
	task automatic drain(input int settle);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (expected_beats.size() != 0 && waited < 20000);
		if (expected_beats.size() != 0) begin
			$error("%0d expected beats never arrived", expected_beats.size());
			faults++;
			expected_beats.delete();
		end
		@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_NOTES: cap_notes = val[7:0];
			CFG_START_LENGTH: boot_len = val[5:0];
			CFG_START_OCTAVE: boot_oct = val[3:0];
			CFG_START_TEMPO: boot_bpm = val;
			CFG_OCTAVE_FLOOR: oct_lo = val[3:0];
			CFG_OCTAVE_CEILING: oct_hi = val[3:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		text.push_back(b);
	endtask

	task automatic add(input string s);
		int i;
		for (i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	task automatic ship();
		int i;
		for (i = 0; i < text.size(); i++) begin
			if ($urandom_range(299) == 0) drain(0);
			send_byte(text[i], i == text.size() - 1);
		end
		text.delete();
	endtask

	task automatic add_setting();
		logic [7:0] k;
		int v;
		case ($urandom_range(9))
			0, 1, 2: k = CH_LD;
			3, 4, 5: k = CH_LO;
			6, 7, 8: k = CH_LB;
			default: k = CH_LA + 8'($urandom_range(25));
		endcase
		if ($urandom_range(1)) k = k - CASE_OFS;
		add_byte(k);
		if ($urandom_range(9) == 0) begin
			add_byte(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(7) == 0) add_byte(CH_SP);
		add_byte(CH_EQ);
		if ($urandom_range(7) == 0) add_byte(CH_SP);
		if ($urandom_range(15) == 0) return;
		case ($urandom_range(5))
			0: v = $urandom_range(15);
			1: v = 1 << $urandom_range(5);
			2: v = $urandom_range(70);
			3: v = $urandom_range(65535);
			4: v = $urandom_range(999999, 65530);
			default: v = $urandom_range(300);
		endcase
		if ($urandom_range(7) == 0) add_byte(CH_0);
		add($sformatf("%0d", v));
	endtask

	task automatic add_note();
		logic [2:0] t;
		logic [7:0] c;
		int v;
		if ($urandom_range(3) == 0) add_byte(CH_SP);
		if ($urandom_range(1)) begin
			case ($urandom_range(5))
				0: v = $urandom_range(99);
				1: v = $urandom_range(999999);
				default: v = 1 << $urandom_range(5);
			endcase
			add($sformatf("%0d", v));
			if ($urandom_range(9) == 0) add_byte(CH_TAB);
		end
		if ($urandom_range(11) == 0) begin
			add_byte(8'($urandom_range(255)));
		end else begin
			t = 3'($urandom_range(7));
			c = (t == TONE_PAUSE) ? CH_LP : CH_LA + {5'd0, t};
			if ($urandom_range(1)) c = c - CASE_OFS;
			add_byte(c);
		end
		if ($urandom_range(2) == 0) add_byte(CH_HASH);
		repeat ($urandom_range(3)) begin
			case ($urandom_range(4))
				0: add_byte(CH_DOT);
				1: add($sformatf("%0d", $urandom_range(99999)));
				2, 3: add($sformatf("%0d", $urandom_range(15)));
				default: add_byte(CH_SP);
			endcase
		end
		if ($urandom_range(14) == 0) add_byte(8'($urandom_range(255)));
	endtask

	task automatic compose_text();
		logic [7:0] c;
		int i;
		int n;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(3)) begin
			c = 8'($urandom_range(255));
			if (c == CH_COLON || c == CH_NUL) c = CH_LA;
			add_byte(c);
		end
		add_byte(CH_COLON);
		n = $urandom_range(3);
		for (i = 0; i < n; i++) begin
			if (i > 0) begin
				case ($urandom_range(5))
					0: ;
					1: add(", ");
					default: add_byte(CH_COMMA);
				endcase
			end
			add_setting();
		end
		if ($urandom_range(19) != 0) add_byte(CH_COLON);
		n = $urandom_range(6);
		for (i = 0; i < n; i++) begin
			if (i > 0) add_byte(CH_COMMA);
			add_note();
		end
		if ($urandom_range(9) == 0) add_byte(CH_COMMA);
		case ($urandom_range(19))
			0, 1: begin
				add_byte(CH_NUL);
				repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
			end
			2: add_byte(CH_NUL);
			default: ;
		endcase
	endtask

	task automatic shuffle_config();
		logic [3:0] lo;
		logic [3:0] hi;
		logic [3:0] swap;
		case ($urandom_range(4))
			0: write_reg(CFG_MAX_NOTES, 16'd0);
			1: write_reg(CFG_MAX_NOTES, 16'd1);
			2: write_reg(CFG_MAX_NOTES, 16'd2);
			3: write_reg(CFG_MAX_NOTES, 16'd255);
			default: write_reg(CFG_MAX_NOTES, 16'($urandom_range(255)));
		endcase
		case ($urandom_range(3))
			0: write_reg(CFG_START_LENGTH, 16'd1);
			1: write_reg(CFG_START_LENGTH, 16'd32);
			2: write_reg(CFG_START_LENGTH, 16'd1 << $urandom_range(5));
			default: write_reg(CFG_START_LENGTH, 16'($urandom_range(63)));
		endcase
		case ($urandom_range(3))
			0: write_reg(CFG_START_OCTAVE, 16'd0);
			1: write_reg(CFG_START_OCTAVE, 16'd15);
			default: write_reg(CFG_START_OCTAVE, 16'($urandom_range(15)));
		endcase
		case ($urandom_range(4))
			0: write_reg(CFG_START_TEMPO, 16'd1);
			1: write_reg(CFG_START_TEMPO, 16'd65535);
			2: write_reg(CFG_START_TEMPO, 16'd0);
			default: write_reg(CFG_START_TEMPO, 16'($urandom_range(65535, 1)));
		endcase
		lo = 4'($urandom_range(15));
		hi = 4'($urandom_range(15));
		if ($urandom_range(3) != 0 && lo > hi) begin
			swap = lo;
			lo = hi;
			hi = swap;
		end
		if ($urandom_range(5) == 0) begin
			lo = 4'd0;
			hi = 4'd15;
		end
		write_reg(CFG_OCTAVE_FLOOR, {12'd0, lo});
		write_reg(CFG_OCTAVE_CEILING, {12'd0, hi});
	endtask

	task automatic test_unterminated_name();
		add("r");
		add_byte(8'hFF);
		add_byte(CH_NUL);
		add("z:");
		ship();
		add_byte(CH_COLON);
		add_byte(CH_NUL);
		ship();
		drain(4);
	endtask

	task automatic test_defaults_section();
		add(":d=16,o=5,b=99999,Kx,:c");
		ship();
		add(":d=3 o=9:p");
		ship();
		drain(4);
	endtask

	task automatic test_note_syntax();
		add(":: 64p5.,8G#.17,3c,x,e#z");
		ship();
		drain(4);
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_MAX_NOTES, 16'd1);
		write_reg(CFG_START_LENGTH, 16'd3);
		write_reg(CFG_START_OCTAVE, 16'd15);
		write_reg(CFG_START_TEMPO, 16'd0);
		write_reg(CFG_OCTAVE_FLOOR, 16'd9);
		write_reg(CFG_OCTAVE_CEILING, 16'd2);
		add(":b=0:c1,d");
		ship();
		drain(4);
		write_reg(CFG_MAX_NOTES, 16'd0);
		write_reg(CFG_START_LENGTH, 16'd32);
		write_reg(CFG_START_OCTAVE, 16'd0);
		write_reg(CFG_START_TEMPO, 16'd65535);
		write_reg(CFG_OCTAVE_FLOOR, 16'd0);
		write_reg(CFG_OCTAVE_CEILING, 16'd15);
		add(":o=15:a");
		ship();
		drain(4);
	endtask

	task automatic test_random_texts();
		int phase;
		int round;
		int goal;
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = send_idle_by_phase[phase];
			stall_pct = recv_stall_by_phase[phase];
			for (round = 0; round < 3; round++) begin
				drain(4);
				shuffle_config();
				goal = sent + 100;
				while (sent < goal) begin
					compose_text();
					ship();
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unterminated_name();
		test_defaults_section();
		test_note_syntax();
		test_config_extremes();
		test_random_texts();
		drain(8);
		if (faults == 0)
			$display("ringtone_text_parser_core_test passed");
		else
			$display("ringtone_text_parser_core_test failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("ringtone_text_parser_core_test failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rtp_pkg.sv
hw/rtl/ringtone_text_parser_core.sv
hw/rtl/rtp_checker.sv
bench/ringtone_text_parser_core_test.sv
